FILE: design/cmc_pkg.sv
// ============================================================================
// cmc_pkg : shared types and constants of the confusion matrix counter
// Opcodes, command format between front and back, result codes and
// back-end states.
// ============================================================================
package cmc_pkg;

  // Fixed field widths on the ports
  localparam int SCORE_IN_W  = 32;
  localparam int CLASS_W     = 4;
  localparam int COUNT_OUT_W = 32;

  // Cell address in a command; wide enough for the largest supported table (64 x 64)
  localparam int CELL_ADDR_W = 12;

  // Command queue between front and back
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = 2;

  typedef enum logic [1:0] {
    OP_PAIR  = 2'd0,
    OP_READ  = 2'd1,
    OP_CLEAR = 2'd2,
    OP_RSVD  = 2'd3
  } opcode_t;

  typedef enum logic [1:0] {
    CMD_CLASSIFY = 2'd0,
    CMD_READ     = 2'd1,
    CMD_CLEAR    = 2'd2
  } cmd_kind_t;

  typedef enum logic {
    RES_CLASSIFY = 1'b0,
    RES_READ     = 1'b1
  } result_kind_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_MISMATCH = 2'd1,
    ST_RANGE    = 2'd2
  } status_t;

  typedef enum logic {
    BK_IDLE = 1'b0,
    BK_LOOK = 1'b1
  } back_state_t;

  // One table operation as handed from front to back
  typedef struct packed {
    cmd_kind_t              kind;
    logic                   fault;       // length mismatch or read out of range
    logic                   is_correct;
    logic [CLASS_W-1:0]     target_class;
    logic [CLASS_W-1:0]     predicted_class;
    logic [CELL_ADDR_W-1:0] addr;
  } cmd_t;

endpackage

FILE: design/cmc_if.sv
// ============================================================================
// cmc_if : channel interfaces of the confusion matrix counter
// Input item channel, result channel and register write channel, each
// with valid/ready handshake.
// ============================================================================

// Input item channel
interface cmc_in_if;
  logic                                  valid;
  logic                                  ready;
  logic [1:0]                            opcode;
  logic signed [cmc_pkg::SCORE_IN_W-1:0] predicted_score;
  logic signed [cmc_pkg::SCORE_IN_W-1:0] target_score;
  logic                                  last_element;
  logic [3:0]                            read_row;
  logic [3:0]                            read_col;

  modport source (output valid, opcode, predicted_score, target_score, last_element,
                  read_row, read_col, input ready);
  modport sink   (input valid, opcode, predicted_score, target_score, last_element,
                  read_row, read_col, output ready);
endinterface

// Result channel
interface cmc_out_if;
  logic                               valid;
  logic                               ready;
  logic                               result_kind;
  logic [cmc_pkg::CLASS_W-1:0]        target_class;
  logic [cmc_pkg::CLASS_W-1:0]        predicted_class;
  logic                               is_correct;
  logic [cmc_pkg::COUNT_OUT_W-1:0]    cell_count;
  logic [1:0]                         status;

  modport source (output valid, result_kind, target_class, predicted_class, is_correct,
                  cell_count, status, input ready);
  modport sink   (input valid, result_kind, target_class, predicted_class, is_correct,
                  cell_count, status, output ready);
endinterface

// Register write channel
interface cmc_cfg_if;
  logic       valid;
  logic       ready;
  logic [4:0] num_classes;

  modport source (output valid, num_classes, input ready);
  modport sink   (input valid, num_classes, output ready);
endinterface

FILE: design/cmc_front.sv
// ============================================================================
// cmc_front : item intake and classification
// Tracks the running argmax of both score vectors, checks lengths and read
// ranges, and turns each item that needs the table into a queued command.
// ============================================================================
module cmc_front #(
  parameter int MAX_CLASSES = 16,
  parameter int SCORE_WIDTH = 32
) (
  input  logic          clk,
  input  logic          rst,
  cmc_in_if.sink        sample,
  cmc_cfg_if.sink       cfg,
  input  logic          q_full,
  output logic          push,
  output cmc_pkg::cmd_t push_cmd
);

  // Pair counter saturates one past the largest class count
  localparam int CW  = $clog2(MAX_CLASSES + 2);
  localparam int CAP = MAX_CLASSES + 1;
  localparam logic [6:0] MAXC = 7'(MAX_CLASSES);
  localparam logic [cmc_pkg::CELL_ADDR_W-1:0] ROW_STRIDE =
    cmc_pkg::CELL_ADDR_W'(MAX_CLASSES);

  logic [4:0]                    num_classes;
  logic [CW-1:0]                 elem;
  logic [CW-1:0]                 elem_inc;
  logic signed [SCORE_WIDTH-1:0] best_p;
  logic signed [SCORE_WIDTH-1:0] best_t;
  logic signed [SCORE_WIDTH-1:0] sc_p;
  logic signed [SCORE_WIDTH-1:0] sc_t;
  logic [CW-1:0]                 best_p_idx;
  logic [CW-1:0]                 best_t_idx;
  logic [CW-1:0]                 p_idx_new;
  logic [CW-1:0]                 t_idx_new;
  logic                          first;
  logic                          take_p;
  logic                          take_t;
  logic                          accept;
  logic                          pair_acc;
  logic                          nc_ok;
  logic                          len_bad;
  logic                          read_bad;
  logic [6:0]                    count_w;
  logic [6:0]                    nc_w;
  logic [6:0]                    row_w;
  logic [6:0]                    col_w;

  // Handshakes
  assign sample.ready = !q_full;
  assign cfg.ready    = 1'b1;
  assign accept       = sample.valid && sample.ready;
  assign pair_acc     = accept &&
                        (cmc_pkg::opcode_t'(sample.opcode) == cmc_pkg::OP_PAIR);

  // Class count register
  always_ff @(posedge clk) begin
    if (rst) begin
      num_classes <= 5'd2;
    end else if (cfg.valid) begin
      num_classes <= cfg.num_classes;
    end
  end

  // Argmax compare: strict greater, so ties keep the earlier index
  always_comb begin
    sc_p      = SCORE_WIDTH'(sample.predicted_score);
    sc_t      = SCORE_WIDTH'(sample.target_score);
    first     = (elem == '0);
    take_p    = first || (sc_p > best_p);
    take_t    = first || (sc_t > best_t);
    p_idx_new = take_p ? elem : best_p_idx;
    t_idx_new = take_t ? elem : best_t_idx;
    elem_inc  = (elem < CW'(CAP)) ? CW'(elem + 1'b1) : elem;
  end

  // Length and range checks
  always_comb begin
    count_w  = 7'(elem_inc);
    nc_w     = 7'(num_classes);
    row_w    = 7'(sample.read_row);
    col_w    = 7'(sample.read_col);
    nc_ok    = (nc_w != 7'd0) && (nc_w <= MAXC);
    len_bad  = !nc_ok || (count_w != nc_w) ||
               (7'(t_idx_new) >= MAXC) || (7'(p_idx_new) >= MAXC);
    read_bad = !nc_ok || (row_w >= nc_w) || (col_w >= nc_w) ||
               (row_w >= MAXC) || (col_w >= MAXC);
  end

  // Running argmax state
  always_ff @(posedge clk) begin
    if (rst) begin
      elem <= '0;
    end else if (pair_acc) begin
      elem <= sample.last_element ? '0 : elem_inc;
    end
  end

  always_ff @(posedge clk) begin
    if (pair_acc) begin
      best_p     <= take_p ? sc_p : best_p;
      best_t     <= take_t ? sc_t : best_t;
      best_p_idx <= p_idx_new;
      best_t_idx <= t_idx_new;
    end
  end

  // Command build
  always_comb begin
    push     = 1'b0;
    push_cmd = '0;
    if (accept) begin
      unique case (cmc_pkg::opcode_t'(sample.opcode))
        cmc_pkg::OP_PAIR: begin
          if (sample.last_element) begin
            push                     = 1'b1;
            push_cmd.kind            = cmc_pkg::CMD_CLASSIFY;
            push_cmd.fault           = len_bad;
            push_cmd.is_correct      = (t_idx_new == p_idx_new);
            push_cmd.target_class    = cmc_pkg::CLASS_W'(t_idx_new);
            push_cmd.predicted_class = cmc_pkg::CLASS_W'(p_idx_new);
            push_cmd.addr = cmc_pkg::CELL_ADDR_W'(t_idx_new) * ROW_STRIDE +
                            cmc_pkg::CELL_ADDR_W'(p_idx_new);
          end
        end
        cmc_pkg::OP_READ: begin
          push           = 1'b1;
          push_cmd.kind  = cmc_pkg::CMD_READ;
          push_cmd.fault = read_bad;
          push_cmd.addr  = cmc_pkg::CELL_ADDR_W'(sample.read_row) * ROW_STRIDE +
                           cmc_pkg::CELL_ADDR_W'(sample.read_col);
        end
        cmc_pkg::OP_CLEAR: begin
          push          = 1'b1;
          push_cmd.kind = cmc_pkg::CMD_CLEAR;
        end
        cmc_pkg::OP_RSVD: begin
          push = 1'b0;
        end
      endcase
    end
  end

endmodule

FILE: design/cmc_queue.sv
// ============================================================================
// cmc_queue : command queue between front and back
// Small FIFO of table commands so intake and table work stall apart.
// ============================================================================
module cmc_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  cmc_pkg::cmd_t push_cmd,
  output logic          full,
  input  logic          pop,
  output cmc_pkg::cmd_t head,
  output logic          empty
);

  cmc_pkg::cmd_t               slots [cmc_pkg::QUEUE_DEPTH];
  logic [cmc_pkg::QPTR_W-1:0]  wr_ptr;
  logic [cmc_pkg::QPTR_W-1:0]  rd_ptr;
  logic [cmc_pkg::QPTR_W:0]    fill;

  assign full  = (fill == (cmc_pkg::QPTR_W + 1)'(cmc_pkg::QUEUE_DEPTH));
  assign empty = (fill == '0);
  assign head  = slots[rd_ptr];

  // Storage
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_cmd;
    end
  end

  // Pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      unique case ({push, pop})
        2'b10:   fill <= fill + 1'b1;
        2'b01:   fill <= fill - 1'b1;
        default: fill <= fill;
      endcase
    end
  end

endmodule

FILE: design/cmc_back.sv
// ============================================================================
// cmc_back : count table and result stage
// Runs queued commands one at a time against the count table: saturating
// increment, cell read or clear, and holds each result in an output register.
// ============================================================================
module cmc_back #(
  parameter int MAX_CLASSES = 16,
  parameter int COUNT_WIDTH = 32
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          q_empty,
  input  cmc_pkg::cmd_t head,
  output logic          pop,
  cmc_out_if.source     result
);

  localparam int CELLS = MAX_CLASSES * MAX_CLASSES;
  localparam int AW    = (CELLS > 1) ? $clog2(CELLS) : 1;

  logic [COUNT_WIDTH-1:0] table_mem [CELLS];
  logic [CELLS-1:0]       filled;
  logic [COUNT_WIDTH-1:0] rd_data;
  logic [COUNT_WIDTH-1:0] cnt;
  logic [COUNT_WIDTH-1:0] cnt_inc;
  cmc_pkg::cmd_t          cmd;
  cmc_pkg::back_state_t   state;
  cmc_pkg::back_state_t   state_next;
  logic [AW-1:0]          head_addr;
  logic [AW-1:0]          cur_addr;
  logic                   can_load;
  logic                   load;
  logic                   we;
  logic                   clear_all;

  assign head_addr = head.addr[AW-1:0];
  assign cur_addr  = cmd.addr[AW-1:0];
  assign can_load  = !result.valid || result.ready;

  // A cell never written since the last clear counts as zero
  assign cnt     = filled[cur_addr] ? rd_data : '0;
  assign cnt_inc = (cnt == '1) ? cnt : cnt + 1'b1;

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      cmc_pkg::BK_IDLE: begin
        if (!q_empty && (head.kind != cmc_pkg::CMD_CLEAR)) begin
          state_next = cmc_pkg::BK_LOOK;
        end
      end
      cmc_pkg::BK_LOOK: begin
        if (can_load) begin
          state_next = cmc_pkg::BK_IDLE;
        end
      end
    endcase
  end

  // Control outputs
  always_comb begin
    pop       = 1'b0;
    clear_all = 1'b0;
    load      = 1'b0;
    we        = 1'b0;
    unique case (state)
      cmc_pkg::BK_IDLE: begin
        pop       = !q_empty;
        clear_all = !q_empty && (head.kind == cmc_pkg::CMD_CLEAR);
      end
      cmc_pkg::BK_LOOK: begin
        load = can_load;
        we   = can_load && (cmd.kind == cmc_pkg::CMD_CLASSIFY) && !cmd.fault;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= cmc_pkg::BK_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Table memory: one read port (issued at pop), one write port
  always_ff @(posedge clk) begin
    if (we) begin
      table_mem[cur_addr] <= cnt_inc;
    end
    if (pop) begin
      rd_data <= table_mem[head_addr];
    end
  end

  // Per-cell written flags; clear wipes the whole table at once
  always_ff @(posedge clk) begin
    if (rst || clear_all) begin
      filled <= '0;
    end else if (we) begin
      filled[cur_addr] <= 1'b1;
    end
  end

  // Current command
  always_ff @(posedge clk) begin
    if (pop) begin
      cmd <= head;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (load) begin
      result.valid <= 1'b1;
    end else if (result.ready) begin
      result.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      result.target_class    <= '0;
      result.predicted_class <= '0;
      result.is_correct      <= 1'b0;
      result.cell_count      <= '0;
      result.status          <= cmc_pkg::ST_OK;
      if (cmd.kind == cmc_pkg::CMD_READ) begin
        result.result_kind <= cmc_pkg::RES_READ;
        if (cmd.fault) begin
          result.status <= cmc_pkg::ST_RANGE;
        end else begin
          result.cell_count <= cmc_pkg::COUNT_OUT_W'(cnt);
        end
      end else begin
        result.result_kind <= cmc_pkg::RES_CLASSIFY;
        if (cmd.fault) begin
          result.status <= cmc_pkg::ST_MISMATCH;
        end else begin
          result.target_class    <= cmd.target_class;
          result.predicted_class <= cmd.predicted_class;
          result.is_correct      <= cmd.is_correct;
        end
      end
    end
  end

endmodule

FILE: design/confusion_matrix_counter_unit.sv
// ============================================================================
// confusion_matrix_counter_unit : streaming argmax confusion-matrix counter
// Top level: intake front, command queue and count-table back end.
// ============================================================================
// Usage:
//   sample carries one item per handshake: a score element pair (opcode 0),
//   a cell read (opcode 1) or a table clear (opcode 2). Element pairs are
//   taken one per cycle while the queue is not full; only the last pair of an example queues work.
//   result carries one item per classified example or per cell read.
//   cfg writes num_classes; write it only while the block is idle.
// Path: an accepted item is written into the queue, popped into the back
//   end command and table read registers, then loaded into the result register.
// Throughput: element pairs 1 per cycle while the queue is not full; the
//   back end runs a classification or read in IDLE (pop, registered table
//   read) then LOOK (increment, result load), a clear in IDLE alone. A
//   4-entry command queue absorbs bursts; sample.ready drops only when it is full.
// Reset: the table reads as all zero at once through per-cell written
//   flags, no clearing pass; num_classes returns to 2.
// Stall: while result is not taken the result register holds, the back end
//   waits, and the queue keeps filling until it backs up to sample.
// ============================================================================
module confusion_matrix_counter_unit #(
  parameter int MAX_CLASSES = 16,
  parameter int SCORE_WIDTH = 32,
  parameter int COUNT_WIDTH = 32
) (
  input  logic      clk,
  input  logic      rst,
  cmc_in_if.sink    sample,
  cmc_cfg_if.sink   cfg,
  cmc_out_if.source result
);

  logic          push;
  logic          q_full;
  logic          q_empty;
  logic          pop;
  cmc_pkg::cmd_t push_cmd;
  cmc_pkg::cmd_t head;

  // Intake and classification
  cmc_front #(
    .MAX_CLASSES (MAX_CLASSES),
    .SCORE_WIDTH (SCORE_WIDTH)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .sample   (sample),
    .cfg      (cfg),
    .q_full   (q_full),
    .push     (push),
    .push_cmd (push_cmd)
  );

  // Command queue
  cmc_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .full     (q_full),
    .pop      (pop),
    .head     (head),
    .empty    (q_empty)
  );

  // Table and result stage
  cmc_back #(
    .MAX_CLASSES (MAX_CLASSES),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_back (
    .clk     (clk),
    .rst     (rst),
    .q_empty (q_empty),
    .head    (head),
    .pop     (pop),
    .result  (result)
  );

`ifndef SYNTHESIS
  // An out-of-range read reports no count
  a_range_read: assert property (@(posedge clk) disable iff (rst)
    (result.valid && result.status == cmc_pkg::ST_RANGE) |->
    (result.result_kind == cmc_pkg::RES_READ && result.cell_count == '0))
    else $error("out-of-range read carries data");

  // A length mismatch reports no classes
  a_mismatch: assert property (@(posedge clk) disable iff (rst)
    (result.valid && result.status == cmc_pkg::ST_MISMATCH) |->
    (result.result_kind == cmc_pkg::RES_CLASSIFY && result.target_class == '0 &&
     result.predicted_class == '0 && !result.is_correct))
    else $error("mismatched example carries classes");

  // Nothing is offered straight after reset
  a_reset_quiet: assert property (@(posedge clk)
    $past(rst) |-> !result.valid)
    else $error("result valid after reset");
`endif

endmodule

FILE: tb/confusion_matrix_counter_unit_tb.sv
`timescale 1ns / 100ps
// ============================================================================
// confusion_matrix_counter_unit_tb : self-checking bench of the matrix counter
// Drives score pairs, cell reads, clears and reserved items through the
// sample channel: a table of directed rows first, then a long receiver hold
// and random phases under several class counts. An in-bench model of the
// argmax and count table predicts every result that a directed row does not
// pin; results are compared field by field in order.
// ============================================================================
module confusion_matrix_counter_unit_tb;

  localparam int          MAXC      = 16;
  localparam logic [31:0] CNT_CAP   = 32'hFFFF_FFFF;
  localparam int          DRAIN     = 10;
  localparam int          LONG_HOLD = 80;
  localparam int          LIMIT     = 100000;
  localparam int          N_PHASES  = 8;
  localparam int          PHASE_LEN = 135;

  typedef struct {
    cmc_pkg::result_kind_t kind;
    logic [3:0]            tcls;
    logic [3:0]            pcls;
    logic                  hit;
    logic [31:0]           cnt;
    cmc_pkg::status_t      st;
  } res_t;

  typedef struct {
    cmc_pkg::opcode_t op;
    logic [31:0]      ps;
    logic [31:0]      ts;
    logic             last;
    logic [3:0]       row;
    logic [3:0]       col;
    bit               pinned;
    res_t             want;
  } item_t;

  logic clk = 1'b0;
  logic rst;

  cmc_in_if  sample_if();
  cmc_cfg_if cfg_if();
  cmc_out_if result_if();

  confusion_matrix_counter_unit uut (
    .clk    (clk),
    .rst    (rst),
    .sample (sample_if),
    .cfg    (cfg_if),
    .result (result_if)
  );

  // Clock
  initial begin
    forever #10 clk = ~clk;
  end

  // Model state
  logic [31:0] tally [MAXC*MAXC];
  int          pairs_seen;
  logic [31:0] lead_p;
  logic [31:0] lead_t;
  int          lead_pi;
  int          lead_ti;
  logic [4:0]  classes;

  res_t pending [$];
  int   gap_pct   = 0;
  int   stall_pct = 0;
  bit   hold_req  = 1'b0;
  int   hold_left = 0;
  int   rx_gap    = 0;
  int   cycles    = 0;
  int   errors    = 0;
  int   n_items   = 0;
  int   n_results = 0;
  int   n_cls     = 0;
  int   n_reads   = 0;
  int   n_faults  = 0;
  int   n_cfg     = 0;
  int   n_stall   = 0;
  int   n_long    = 0;

  function automatic void model_reset();
    foreach (tally[i]) tally[i] = '0;
    pairs_seen = 0;
    lead_p     = '0;
    lead_t     = '0;
    lead_pi    = 0;
    lead_ti    = 0;
    classes    = 5'd2;
  endfunction

  // Argmax and count table update for one item; returns 1 when a result is due
  function automatic bit matrix_step(input item_t it, output res_t r);
    int n;
    int k;
    r = '{kind: cmc_pkg::RES_CLASSIFY, tcls: 4'd0, pcls: 4'd0, hit: 1'b0, cnt: 32'd0,
          st: cmc_pkg::ST_OK};
    case (it.op)
      cmc_pkg::OP_PAIR: begin
        if (pairs_seen == 0) begin
          lead_p  = it.ps;
          lead_pi = 0;
          lead_t  = it.ts;
          lead_ti = 0;
        end else begin
          // strict compare: on a tie the earlier index stays
          if ($signed(it.ps) > $signed(lead_p)) begin
            lead_p  = it.ps;
            lead_pi = pairs_seen;
          end
          if ($signed(it.ts) > $signed(lead_t)) begin
            lead_t  = it.ts;
            lead_ti = pairs_seen;
          end
        end
        if (pairs_seen < MAXC + 1) pairs_seen++;
        if (!it.last) return 1'b0;
        n = pairs_seen;
        pairs_seen = 0;
        if (classes == 5'd0 || classes > 5'(MAXC) || n != int'(classes) ||
            lead_ti >= MAXC || lead_pi >= MAXC) begin
          r.st = cmc_pkg::ST_MISMATCH;
          return 1'b1;
        end
        k = lead_ti * MAXC + lead_pi;
        if (tally[k] != CNT_CAP) tally[k] = tally[k] + 32'd1;
        r.tcls = lead_ti[3:0];
        r.pcls = lead_pi[3:0];
        r.hit  = (lead_ti == lead_pi);
        return 1'b1;
      end
      cmc_pkg::OP_READ: begin
        r.kind = cmc_pkg::RES_READ;
        if (classes == 5'd0 || classes > 5'(MAXC) ||
            5'(it.row) >= classes || 5'(it.col) >= classes) begin
          r.st = cmc_pkg::ST_RANGE;
        end else begin
          r.cnt = tally[int'(it.row) * MAXC + int'(it.col)];
        end
        return 1'b1;
      end
      cmc_pkg::OP_CLEAR: begin
        foreach (tally[i]) tally[i] = '0;
        return 1'b0;
      end
      default: return 1'b0;
    endcase
  endfunction

  // Item builders
  function automatic item_t pair(input logic [31:0] ps, input logic [31:0] ts,
                                 input logic last);
    item_t it;
    it.op     = cmc_pkg::OP_PAIR;
    it.ps     = ps;
    it.ts     = ts;
    it.last   = last;
    it.row    = 4'($urandom_range(0, 15));
    it.col    = 4'($urandom_range(0, 15));
    it.pinned = 1'b0;
    return it;
  endfunction

  function automatic item_t rd(input int row, input int col);
    item_t it;
    it = pair($urandom(), $urandom(), 1'($urandom_range(0, 1)));
    it.op  = cmc_pkg::OP_READ;
    it.row = 4'(row);
    it.col = 4'(col);
    return it;
  endfunction

  function automatic item_t ctl(input cmc_pkg::opcode_t op);
    item_t it;
    it = pair($urandom(), $urandom(), 1'($urandom_range(0, 1)));
    it.op = op;
    return it;
  endfunction

  function automatic item_t pin(input item_t it, input res_t r);
    it.pinned = 1'b1;
    it.want   = r;
    return it;
  endfunction

  function automatic res_t cls_res(input int t, input int p);
    return '{kind: cmc_pkg::RES_CLASSIFY, tcls: 4'(t), pcls: 4'(p), hit: (t == p),
             cnt: 32'd0, st: cmc_pkg::ST_OK};
  endfunction

  function automatic res_t read_res(input int c);
    return '{kind: cmc_pkg::RES_READ, tcls: 4'd0, pcls: 4'd0, hit: 1'b0, cnt: 32'(c),
             st: cmc_pkg::ST_OK};
  endfunction

  function automatic res_t fault_res(input cmc_pkg::result_kind_t k,
                                     input cmc_pkg::status_t s);
    return '{kind: k, tcls: 4'd0, pcls: 4'd0, hit: 1'b0, cnt: 32'd0, st: s};
  endfunction

  // Scores biased towards extremes and small values that tie
  function automatic logic [31:0] score();
    case ($urandom_range(0, 5))
      0:       return 32'h7FFF_FFFF;
      1:       return 32'h8000_0000;
      2:       return 32'($urandom_range(0, 3));
      3:       return 32'hFFFF_FFFF - 32'($urandom_range(0, 2));
      default: return $urandom();
    endcase
  endfunction

  // Cell index, mostly inside the current table
  function automatic int pick_idx();
    if (classes >= 5'd1 && classes <= 5'(MAXC) && $urandom_range(0, 9) < 7)
      return int'($urandom_range(0, int'(classes) - 1));
    return int'($urandom_range(0, 15));
  endfunction

  task automatic mism(input string what, input logic [31:0] want, input logic [31:0] got);
    errors++;
    $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
  endtask

  task automatic check_result(input res_t w);
    if (result_if.result_kind !== w.kind)
      mism("result_kind", 32'(w.kind), 32'(result_if.result_kind));
    if (result_if.target_class !== w.tcls)
      mism("target_class", 32'(w.tcls), 32'(result_if.target_class));
    if (result_if.predicted_class !== w.pcls)
      mism("predicted_class", 32'(w.pcls), 32'(result_if.predicted_class));
    if (result_if.is_correct !== w.hit)
      mism("is_correct", 32'(w.hit), 32'(result_if.is_correct));
    if (result_if.cell_count !== w.cnt)
      mism("cell_count", w.cnt, result_if.cell_count);
    if (result_if.status !== w.st)
      mism("status", 32'(w.st), 32'(result_if.status));
  endtask

  // Offer one item and wait for it to be taken, then predict its result
  task automatic send(input item_t it);
    res_t r;
    bit   due;
    if (gap_pct > 0 && $urandom_range(0, 99) < gap_pct) begin
      sample_if.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    sample_if.valid           <= 1'b1;
    sample_if.opcode          <= it.op;
    sample_if.predicted_score <= it.ps;
    sample_if.target_score    <= it.ts;
    sample_if.last_element    <= it.last;
    sample_if.read_row        <= it.row;
    sample_if.read_col        <= it.col;
    @(posedge clk);
    while (!sample_if.ready) begin
      n_stall++;
      @(posedge clk);
    end
    n_items++;
    due = matrix_step(it, r);
    if (due) begin
      pending.push_back(it.pinned ? it.want : r);
      if (r.kind == cmc_pkg::RES_READ) n_reads++;
      else n_cls++;
      if (r.st != cmc_pkg::ST_OK) n_faults++;
    end
  endtask

  // One example, now and then of the wrong length
  task automatic send_example();
    int len;
    len = (classes >= 5'd1 && classes <= 5'(MAXC)) ? int'(classes) : 4;
    if ($urandom_range(0, 9) == 0) len = int'($urandom_range(1, 20));
    for (int k = 0; k < len; k++) send(pair(score(), score(), (k == len - 1)));
  endtask

  // Wait until every result is taken and the queue has settled
  task automatic drain();
    sample_if.valid <= 1'b0;
    while (pending.size() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
  endtask

  task automatic write_cfg(input logic [4:0] nc);
    cfg_if.valid       <= 1'b1;
    cfg_if.num_classes <= nc;
    @(posedge clk);
    while (!cfg_if.ready) @(posedge clk);
    cfg_if.valid <= 1'b0;
    classes = nc;
    n_cfg++;
  endtask

  // Receiver: random idle bursts, and a long hold on request
  initial begin
    result_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req && hold_left == 0) begin
        hold_left = LONG_HOLD;
        hold_req  = 1'b0;
        n_long++;
      end
      if (hold_left > 0) begin
        hold_left--;
        result_if.ready <= 1'b0;
      end else if (rx_gap > 0) begin
        rx_gap--;
        result_if.ready <= 1'b0;
      end else if (stall_pct > 0 && $urandom_range(0, 99) < stall_pct) begin
        rx_gap = int'($urandom_range(0, 3));
        result_if.ready <= 1'b0;
      end else begin
        result_if.ready <= 1'b1;
      end
    end
  end

  // Result checker
  always @(posedge clk) begin
    if (!rst && result_if.valid && result_if.ready) begin
      n_results++;
      if (pending.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none, actual status %0d",
                 $time, result_if.status);
      end else begin
        check_result(pending.pop_front());
      end
    end
  end

  // Cycle limit
  initial begin
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles >= LIMIT) begin
        $display("%0t: cycle limit %0d reached, %0d results outstanding",
                 $time, LIMIT, pending.size());
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  // Stimulus
  initial begin
    item_t      rows [$];
    logic [4:0] nc_list [N_PHASES];
    int         phase_end;
    int         pick;

    rst                       <= 1'b1;
    sample_if.valid           <= 1'b0;
    sample_if.opcode          <= '0;
    sample_if.predicted_score <= '0;
    sample_if.target_score    <= '0;
    sample_if.last_element    <= 1'b0;
    sample_if.read_row        <= '0;
    sample_if.read_col        <= '0;
    cfg_if.valid              <= 1'b0;
    cfg_if.num_classes        <= '0;
    model_reset();
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Directed rows, two classes after reset
    rows.push_back(pin(rd(0, 0), read_res(0)));
    rows.push_back(pin(rd(2, 0), fault_res(cmc_pkg::RES_READ, cmc_pkg::ST_RANGE)));
    rows.push_back(pin(rd(0, 15), fault_res(cmc_pkg::RES_READ, cmc_pkg::ST_RANGE)));
    rows.push_back(pair(32'd5, 32'd1, 1'b0));
    rows.push_back(pin(pair(32'd7, 32'd1, 1'b1), cls_res(0, 1)));
    rows.push_back(pin(rd(0, 1), read_res(1)));
    // one pair where two are due
    rows.push_back(pin(pair(32'd3, 32'd3, 1'b1),
                       fault_res(cmc_pkg::RES_CLASSIFY, cmc_pkg::ST_MISMATCH)));
    rows.push_back(pair(32'h8000_0000, 32'h7FFF_FFFF, 1'b0));
    rows.push_back(pin(pair(32'h7FFF_FFFF, 32'h8000_0000, 1'b1), cls_res(0, 1)));
    rows.push_back(pin(rd(0, 1), read_res(2)));
    // three pairs where two are due
    rows.push_back(pair(32'd1, 32'd1, 1'b0));
    rows.push_back(pair(32'd2, 32'd2, 1'b0));
    rows.push_back(pin(pair(32'd9, 32'd9, 1'b1),
                       fault_res(cmc_pkg::RES_CLASSIFY, cmc_pkg::ST_MISMATCH)));
    rows.push_back(ctl(cmc_pkg::OP_CLEAR));
    rows.push_back(ctl(cmc_pkg::OP_RSVD));
    rows.push_back(pin(rd(0, 1), read_res(0)));
    rows.push_back(pair(32'hFFFF_FFFF, 32'hFFFF_FFFE, 1'b0));
    rows.push_back(pin(pair(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1), cls_res(1, 0)));
    // clear in the middle of an example leaves the example alone
    rows.push_back(pair(32'd0, 32'd0, 1'b0));
    rows.push_back(ctl(cmc_pkg::OP_CLEAR));
    rows.push_back(pin(pair(32'd1, 32'd1, 1'b1), cls_res(1, 1)));
    rows.push_back(pin(rd(1, 1), read_res(1)));
    rows.push_back(rd(1, 0));
    rows.push_back(rd(0, 0));
    rows.push_back(pair(score(), score(), 1'b0));
    rows.push_back(pair(score(), score(), 1'b1));
    rows.push_back(rd(1, 1));
    gap_pct   = 20;
    stall_pct = 20;
    foreach (rows[i]) send(rows[i]);

    // Receiver holds off while reads and examples pile up
    drain();
    gap_pct   = 0;
    stall_pct = 0;
    hold_req  = 1'b1;
    repeat (10) send(rd(pick_idx(), pick_idx()));
    repeat (5) send_example();

    // Random phases under several class counts, the last without idling
    nc_list = '{5'd1, 5'd5, 5'd0, 5'd16, 5'd17, 5'd3, 5'd31, 5'd2};
    for (int ph = 0; ph < N_PHASES; ph++) begin
      drain();
      write_cfg(nc_list[ph]);
      gap_pct   = (ph == N_PHASES - 1) ? 0 : 25;
      stall_pct = (ph == N_PHASES - 1) ? 0 : 25;
      phase_end = n_items + PHASE_LEN;
      while (n_items < phase_end) begin
        pick = int'($urandom_range(0, 99));
        if (pick < 60) send_example();
        else if (pick < 90) send(rd(pick_idx(), pick_idx()));
        else if (pick < 96) send(ctl(cmc_pkg::OP_CLEAR));
        else send(ctl(cmc_pkg::OP_RSVD));
      end
    end
    drain();

    $display("Covered %0d items over %0d class settings: %0d classifications, %0d reads,",
             n_items, n_cfg, n_cls, n_reads);
    $display("%0d faults, %0d results taken, %0d input stall cycles, %0d long holds.",
             n_faults, n_results, n_stall, n_long);
    if (errors == 0 && pending.size() == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

endmodule
